// ===== sv/bgd_pkg.sv =====
package bgd_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned WRegW    = 12;
  localparam int unsigned HeightW  = 16;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;

  localparam logic OpPixel = 1'b0;
  localparam logic OpDrain = 1'b1;

  typedef struct packed {
    logic pix;
    logic emit;
    logic use_win;
    logic first;
    logic odd_row;
    logic odd_col;
    logic eol;
    logic eof;
  } ctl_t;

  typedef struct packed {
    logic            eof;
    logic            eol;
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
  } out_t;

endpackage

// ===== sv/bgd_ram.sv =====
module bgd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bayer_gr_to_rgb_demosaic.sv =====
// Channel   Dir  Fields (low bit first)                 Handshake
// s_axis    in   tdata: raw_pixel; tuser: opcode         tvalid/tready
// m_axis    out  tdata: red, green, blue; tlast:         tvalid/tready
//                end_of_line; tuser: end_of_frame
// cfg       in   cfg_index_i, cfg_data_i                 cfg_valid_i/cfg_ready_o
//
// One request per clock while s_axis_tready is high; results leave via the queue.
// The line stores sit in one RAM, read once per pixel and written back the next cycle.
// Asynchronous active-low reset; the line RAM is not cleared and needs no sweep.
// A three-entry output queue absorbs m_axis stalls; s_axis stalls while the queue,
// counting the result being written, is full.
module bayer_gr_to_rgb_demosaic #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bgd_pkg::PixW-1:0]      s_axis_tdata,   // raw_pixel
  input  logic                          s_axis_tuser,   // opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [3*bgd_pkg::PixW-1:0]    m_axis_tdata,   // red, green, blue
  output logic                          m_axis_tlast,   // end_of_line
  output logic                          m_axis_tuser,   // end_of_frame
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bgd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bgd_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned PW    = $clog2(MAX_WIDTH + 2);
  localparam int unsigned HW    = bgd_pkg::HeightW;
  localparam int unsigned PixW  = bgd_pkg::PixW;
  localparam int unsigned WRst  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int unsigned HRst  = 480;
  localparam int unsigned QDep  = 3;

  // configuration
  logic [AW-1:0] wm1_q, wm1_d;
  logic [PW-1:0] wp1_q, wp1_d;
  logic [HW-1:0] hm1_q, hm1_d;
  logic          cfg_we;
  logic          restart;
  logic [31:0]   wcl;
  logic [31:0]   hcl;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    wcl = 32'(cfg_data_i[bgd_pkg::WRegW-1:0]);
    if (wcl < 32'd3) begin
      wcl = 32'd3;
    end else if (wcl > 32'(MAX_WIDTH)) begin
      wcl = 32'(MAX_WIDTH);
    end
    hcl = 32'(cfg_data_i[HW-1:0]);
    if (hcl < 32'd3) begin
      hcl = 32'd3;
    end
  end

  always_comb begin
    wm1_d   = wm1_q;
    wp1_d   = wp1_q;
    hm1_d   = hm1_q;
    restart = 1'b0;
    if (cfg_we) begin
      if (cfg_index_i == bgd_pkg::RegImageWidth) begin
        wm1_d   = AW'(wcl - 32'd1);
        wp1_d   = PW'(wcl + 32'd1);
        restart = 1'b1;
      end else if (cfg_index_i == bgd_pkg::RegImageHeight) begin
        hm1_d   = HW'(hcl - 32'd1);
        restart = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q <= AW'(WRst - 1);
      wp1_q <= PW'(WRst + 1);
      hm1_q <= HW'(HRst - 1);
    end else begin
      wm1_q <= wm1_d;
      wp1_q <= wp1_d;
      hm1_q <= hm1_d;
    end
  end

  // accept stage
  logic          in_acc;
  logic          is_pix;
  logic          emit0;
  logic [AW-1:0] col_q, col_d;
  logic [PW-1:0] pend_q, pend_d;
  logic [AW-1:0] ocol_q, ocol_d;
  logic [HW-1:0] orow_q, orow_d;
  bgd_pkg::ctl_t ctl0;

  assign in_acc = s_axis_tvalid & s_axis_tready;
  assign is_pix = (s_axis_tuser == bgd_pkg::OpPixel);
  assign emit0  = is_pix ? (pend_q == wp1_q) : (pend_q != '0);

  always_comb begin
    col_d  = col_q;
    pend_d = pend_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    ctl0.pix     = is_pix;
    ctl0.emit    = emit0;
    ctl0.first   = (orow_q == '0) && (ocol_q == '0);
    ctl0.use_win = is_pix && (orow_q != '0) && (ocol_q != '0) &&
                   (orow_q != hm1_q) && (ocol_q != wm1_q);
    ctl0.odd_row = orow_q[0];
    ctl0.odd_col = ocol_q[0];
    ctl0.eol     = (ocol_q == wm1_q);
    ctl0.eof     = (ocol_q == wm1_q) && (orow_q == hm1_q);
    if (restart) begin
      col_d  = '0;
      pend_d = '0;
      ocol_d = '0;
      orow_d = '0;
    end else if (in_acc) begin
      if (is_pix) begin
        col_d = (col_q == wm1_q) ? '0 : col_q + AW'(1);
        if (!emit0) begin
          pend_d = pend_q + PW'(1);
        end
      end else if (emit0) begin
        pend_d = pend_q - PW'(1);
      end
      if (emit0) begin
        if (ocol_q == wm1_q) begin
          ocol_d = '0;
          orow_d = (orow_q == hm1_q) ? '0 : orow_q + HW'(1);
        end else begin
          ocol_d = ocol_q + AW'(1);
        end
      end
    end
  end

  // line RAM: {above, middle} per column
  logic                v1_q, v1_d;
  bgd_pkg::ctl_t       ctl1_q;
  logic [PixW-1:0]     pix1_q;
  logic [AW-1:0]       col1_q;
  logic [2*PixW-1:0]   ram_rd;
  logic                ram_we;

  assign ram_we = v1_q & ctl1_q.pix;
  assign v1_d   = in_acc & ~restart;

  bgd_ram #(
    .Width(2 * PixW),
    .Depth(1 << AW)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(col1_q),
    .wdata_i({ram_rd[PixW-1:0], pix1_q}),
    .re_i   (in_acc & is_pix),
    .raddr_i(col_q),
    .rdata_o(ram_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      pend_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      v1_q   <= 1'b0;
      ctl1_q <= '0;
    end else begin
      col_q  <= col_d;
      pend_q <= pend_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
      v1_q   <= v1_d;
      if (in_acc) begin
        ctl1_q <= ctl0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix1_q <= s_axis_tdata;
      col1_q <= col_q;
    end
  end

  // window and color stage
  logic [PixW-1:0] win_q [3][3];
  logic [PixW-1:0] win_d [3][3];
  logic [PixW-1:0] last_q [3];
  logic [PixW-1:0] rgb [3];
  logic [PixW:0]   lr_sum;
  logic [PixW:0]   ud_sum;
  logic [PixW+1:0] dg_sum;
  logic [PixW-1:0] lr;
  logic [PixW-1:0] ud;
  logic [PixW-1:0] dg;
  logic [PixW-1:0] ctr;
  logic            push;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win_d[r][c] = win_q[r][c];
      end
    end
    if (ram_we) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r][0] = win_q[r][1];
        win_d[r][1] = win_q[r][2];
      end
      win_d[0][2] = ram_rd[2*PixW-1:PixW];
      win_d[1][2] = ram_rd[PixW-1:0];
      win_d[2][2] = pix1_q;
    end
  end

  assign ctr    = win_d[1][1];
  assign lr_sum = {1'b0, win_d[1][0]} + {1'b0, win_d[1][2]};
  assign ud_sum = {1'b0, win_d[0][1]} + {1'b0, win_d[2][1]};
  assign dg_sum = {2'b00, win_d[0][0]} + {2'b00, win_d[0][2]} +
                  {2'b00, win_d[2][0]} + {2'b00, win_d[2][2]};
  assign lr     = lr_sum[PixW:1];
  assign ud     = ud_sum[PixW:1];
  assign dg     = dg_sum[PixW+1:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rgb[i] = ctl1_q.first ? '0 : last_q[i];
    end
    if (ctl1_q.use_win) begin
      unique case ({ctl1_q.odd_row, ctl1_q.odd_col})
        2'b00: begin
          rgb[0] = lr;  rgb[1] = ctr; rgb[2] = ud;
        end
        2'b01: begin
          rgb[0] = ctr; rgb[1] = ud;  rgb[2] = dg;
        end
        2'b10: begin
          rgb[0] = dg;  rgb[1] = ud;  rgb[2] = ctr;
        end
        default: begin
          rgb[0] = ud;  rgb[1] = ctr; rgb[2] = lr;
        end
      endcase
    end
  end

  assign push = v1_q & ctl1_q.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
        last_q[r] <= '0;
      end
    end else if (restart) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
        last_q[r] <= '0;
      end
    end else begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= win_d[r][c];
        end
      end
      if (push) begin
        for (int i = 0; i < 3; i++) begin
          last_q[i] <= rgb[i];
        end
      end
    end
  end

  // output queue
  bgd_pkg::out_t  q_mem_q [QDep];
  logic [1:0]     wr_ptr_q;
  logic [1:0]     rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           pop;
  logic [2:0]     load;

  assign pop           = m_axis_tvalid & m_axis_tready;
  assign load          = {1'b0, cnt_q} + {2'b00, push};
  assign s_axis_tready = (load < 3'(QDep));
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {q_mem_q[rd_ptr_q].blue, q_mem_q[rd_ptr_q].green,
                          q_mem_q[rd_ptr_q].red};
  assign m_axis_tlast  = q_mem_q[rd_ptr_q].eol;
  assign m_axis_tuser  = q_mem_q[rd_ptr_q].eof;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= '{eof: ctl1_q.eof, eol: ctl1_q.eol,
                             blue: rgb[2], green: rgb[1], red: rgb[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == 2'(QDep - 1)) ? '0 : wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == 2'(QDep - 1)) ? '0 : rd_ptr_q + 2'd1;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== bench/bayer_demosaic_checker.sv =====
`timescale 1ns / 1ps
module bayer_demosaic_checker #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  input  logic                          s_ready_i,
  input  logic [bgd_pkg::PixW-1:0]      s_data_i,    // raw_pixel
  input  logic                          s_user_i,    // opcode
  input  logic                          m_valid_i,
  input  logic                          m_ready_i,
  input  logic [3*bgd_pkg::PixW-1:0]    m_data_i,    // red, green, blue
  input  logic                          m_last_i,    // end_of_line
  input  logic                          m_user_i,    // end_of_frame
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [bgd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bgd_pkg::CfgDataW-1:0]  cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   outstanding_o
);

  localparam int unsigned PixW    = bgd_pkg::PixW;
  localparam int unsigned WRegW   = bgd_pkg::WRegW;
  localparam int unsigned HeightW = bgd_pkg::HeightW;

  localparam logic [1:0] SiteGreenRed  = 2'b00;
  localparam logic [1:0] SiteRed       = 2'b01;
  localparam logic [1:0] SiteBlue      = 2'b10;
  localparam logic [1:0] SiteGreenBlue = 2'b11;

  logic [WRegW-1:0]   width_q;
  logic [HeightW-1:0] height_q;
  logic [PixW-1:0]    above_mem  [MAX_WIDTH];
  logic [PixW-1:0]    middle_mem [MAX_WIDTH];
  logic [PixW-1:0]    win [3][3];
  int unsigned        in_col, in_row, out_col, out_row, backlog;
  int unsigned        mismatch_count;
  bgd_pkg::out_t      held_rgb;
  bgd_pkg::out_t      rgb_due_q [$];

  function automatic int unsigned line_len();
    if (width_q < 3) return 3;
    if (width_q > MAX_WIDTH) return MAX_WIDTH;
    return 32'(width_q);
  endfunction

  function automatic int unsigned frame_lines();
    return (height_q < 3) ? 3 : 32'(height_q);
  endfunction

  function automatic logic [PixW-1:0] mean2(input logic [PixW-1:0] a, b);
    logic [PixW+1:0] sum;
    sum = {2'b00, a} + {2'b00, b};
    return sum[PixW:1];
  endfunction

  function automatic logic [PixW-1:0] mean4(input logic [PixW-1:0] a, b, c, d);
    logic [PixW+1:0] sum;
    sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
    return sum[PixW+1:2];
  endfunction

  function automatic void check_field(input string name, input logic [PixW-1:0] want,
                                      input logic [PixW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic restart_stream();
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    end
    in_col   = 0;
    in_row   = 0;
    out_col  = 0;
    out_row  = 0;
    backlog  = 0;
    held_rgb = '0;
  endtask

  task automatic emit_pixel(input bit from_window);
    int unsigned     w, h;
    logic [PixW-1:0] ctr, horiz, vert, diag;
    logic [1:0]      site;
    bgd_pkg::out_t   px;
    w = line_len();
    h = frame_lines();
    if (out_row == 0 && out_col == 0) held_rgb = '0;
    if (from_window && out_row > 0 && out_col > 0 && out_row < h - 1 && out_col < w - 1) begin
      ctr   = win[1][1];
      horiz = mean2(win[1][0], win[1][2]);
      vert  = mean2(win[0][1], win[2][1]);
      diag  = mean4(win[0][0], win[0][2], win[2][0], win[2][2]);
      site  = {out_row[0], out_col[0]};
      case (site)
        SiteGreenRed: begin
          held_rgb.red   = horiz;
          held_rgb.green = ctr;
          held_rgb.blue  = vert;
        end
        SiteRed: begin
          held_rgb.red   = ctr;
          held_rgb.green = vert;
          held_rgb.blue  = diag;
        end
        SiteBlue: begin
          held_rgb.red   = diag;
          held_rgb.green = vert;
          held_rgb.blue  = ctr;
        end
        SiteGreenBlue: begin
          held_rgb.red   = vert;
          held_rgb.green = ctr;
          held_rgb.blue  = horiz;
        end
      endcase
    end
    px     = held_rgb;
    px.eol = (out_col == w - 1);
    px.eof = px.eol && (out_row == h - 1);
    rgb_due_q.push_back(px);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
  endtask

  task automatic take_sample(input logic op, input logic [PixW-1:0] pix);
    int unsigned     w, h;
    logic [PixW-1:0] above, middle;
    w = line_len();
    h = frame_lines();
    if (op == bgd_pkg::OpDrain) begin
      if (backlog != 0) begin
        emit_pixel(1'b0);
        backlog--;
      end
      return;
    end
    above               = above_mem[in_col];
    middle              = middle_mem[in_col];
    above_mem[in_col]   = middle;
    middle_mem[in_col]  = pix;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = above;
    win[1][2] = middle;
    win[2][2] = pix;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
      if (in_row >= h) in_row = 0;
    end
    backlog++;
    if (backlog > w + 1) begin
      emit_pixel(1'b1);
      backlog--;
    end
  endtask

  task automatic check_result();
    bgd_pkg::out_t want, got;
    got.red   = m_data_i[PixW-1:0];
    got.green = m_data_i[2*PixW-1:PixW];
    got.blue  = m_data_i[3*PixW-1:2*PixW];
    got.eol   = m_last_i;
    got.eof   = m_user_i;
    if (rgb_due_q.size() == 0) begin
      $error("unexpected pixel: red %0d green %0d blue %0d", got.red, got.green, got.blue);
      mismatch_count++;
      return;
    end
    want = rgb_due_q.pop_front();
    check_field("red", want.red, got.red);
    check_field("green", want.green, got.green);
    check_field("blue", want.blue, got.blue);
    check_field("end_of_line", PixW'(want.eol), PixW'(got.eol));
    check_field("end_of_frame", PixW'(want.eof), PixW'(got.eof));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = 12'd640;
      height_q = 16'd480;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        above_mem[i]  = '0;
        middle_mem[i] = '0;
      end
      restart_stream();
      rgb_due_q.delete();
      mismatch_count = 0;
    end else begin
      if (m_valid_i && m_ready_i) check_result();
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == bgd_pkg::RegImageWidth) begin
          width_q = cfg_data_i[WRegW-1:0];
          restart_stream();
        end else if (cfg_index_i == bgd_pkg::RegImageHeight) begin
          height_q = cfg_data_i[HeightW-1:0];
          restart_stream();
        end
      end
      if (s_valid_i && s_ready_i) take_sample(s_user_i, s_data_i);
    end
    fail_count_o  = mismatch_count;
    outstanding_o = rgb_due_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned PixW         = bgd_pkg::PixW;
  localparam int unsigned CfgIdxW      = bgd_pkg::CfgIdxW;
  localparam int unsigned CfgDataW     = bgd_pkg::CfgDataW;
  localparam int unsigned MaxWidth     = 2048;
  localparam int unsigned RandomItems  = 1700;
  localparam int unsigned IdlePercent  = 13;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldAfter    = 150;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned CycleLimit   = 200000;
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PixW-1:0]      s_axis_tdata  = '0;
  logic                 s_axis_tuser  = bgd_pkg::OpPixel;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [3*PixW-1:0]    m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i   = bgd_pkg::RegImageWidth;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 steady        = 1'b0;
  logic                 hold_off      = 1'b0;
  int unsigned          fail_count;
  int unsigned          outstanding;
  int unsigned          cycle_count   = 0;
  int unsigned          sent          = 0;
  logic [PixW-1:0]      tile [16];

  bayer_gr_to_rgb_demosaic #(
    .MAX_WIDTH(MaxWidth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  bayer_demosaic_checker #(
    .MAX_WIDTH(MaxWidth)
  ) rgb_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_last_i     (m_axis_tlast),
    .m_user_i     (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !hold_off && (steady || $urandom_range(0, 99) >= IdlePercent);
  end

  // hold off the receiver once traffic is flowing so the output queue fills
  initial begin
    int unsigned seen;
    seen = 0;
    while (seen < HoldAfter) begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) seen++;
    end
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  task automatic send_request(input logic op, input logic [PixW-1:0] pix);
    while (!steady && $urandom_range(0, 99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic play_stream(input int unsigned pixels, input int unsigned noise_pct,
                             input int unsigned drains);
    for (int unsigned i = 0; i < pixels; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_request(bgd_pkg::OpDrain, PixW'($urandom_range(0, 255)));
        sent++;
      end
      send_request(bgd_pkg::OpPixel, PixW'($urandom_range(0, 255)));
      sent++;
    end
    repeat (drains) begin
      send_request(bgd_pkg::OpDrain, PixW'($urandom_range(0, 255)));
      sent++;
    end
    settle();
  endtask

  initial begin
    int unsigned         w_eff, h_eff, phase;
    logic [CfgDataW-1:0] w_data, h_data;
    tile = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFE, 8'hFF, 8'h01, 8'hFF,
             8'h00, 8'hAA, 8'hFF, 8'h55, 8'hFF, 8'h80, 8'h7F, 8'hFF};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // register defaults straight out of reset
    play_stream(650, 0, 0);

    // 4x4 frame: every site kind gets an interior pixel
    write_register(bgd_pkg::RegImageWidth, 16'hF004);
    write_register(bgd_pkg::RegImageHeight, 16'h0004);
    send_request(bgd_pkg::OpDrain, 8'hFF);
    foreach (tile[i]) send_request(bgd_pkg::OpPixel, tile[i]);
    repeat (7) send_request(bgd_pkg::OpDrain, 8'h00);
    settle();

    write_register(bgd_pkg::RegImageWidth, 16'h0FFF);
    write_register(bgd_pkg::RegImageHeight, 16'h0000);
    play_stream(30, 0, 8);
    write_register(bgd_pkg::RegImageWidth, 16'h0800);
    write_register(bgd_pkg::RegImageHeight, 16'hFFFF);
    play_stream(30, 0, 8);
    write_register(bgd_pkg::RegImageWidth, 16'h5003);
    write_register(bgd_pkg::RegImageHeight, 16'hFFFF);
    play_stream(40, 5, 0);
    write_register(RegSpare, 16'hA5C3);
    play_stream(40, 5, 6);

    phase = 0;
    while (sent < RandomItems) begin
      phase++;
      steady = (phase == 4);
      w_eff  = $urandom_range(0, 9);
      if (w_eff == 0) w_data = CfgDataW'($urandom_range(0, 2));
      else if (w_eff < 7) w_data = CfgDataW'($urandom_range(3, 8));
      else if (w_eff < 9) w_data = CfgDataW'($urandom_range(9, 16));
      else w_data = CfgDataW'($urandom_range(17, 40));
      w_eff = (w_data < 3) ? 3 : 32'(w_data);
      w_data[CfgDataW-1:bgd_pkg::WRegW] = 4'($urandom_range(0, 15));
      h_data = CfgDataW'($urandom_range(0, 6));
      h_eff  = (h_data < 3) ? 3 : 32'(h_data);
      if ($urandom_range(0, 1) == 1) begin
        write_register(bgd_pkg::RegImageWidth, w_data);
        write_register(bgd_pkg::RegImageHeight, h_data);
      end else begin
        write_register(bgd_pkg::RegImageHeight, h_data);
        write_register(bgd_pkg::RegImageWidth, w_data);
      end
      if ($urandom_range(0, 5) == 0) begin
        write_register(RegSpare, CfgDataW'($urandom_range(0, 16'hFFFF)));
      end
      play_stream($urandom_range(1, 3) * w_eff * h_eff + $urandom_range(0, w_eff * h_eff - 1),
                  4, ($urandom_range(0, 1) == 1) ? w_eff + 3 : 0);
    end
    steady = 1'b0;
    settle();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
